FILE: hw/rtl/sfa_pkg.sv
// shared types and constants for the sprite frame animator
`default_nettype none

package sfa_pkg;

  localparam int FRAME_W  = 8;
  localparam int FCOUNT_W = 9;
  localparam int DELAY_W  = 16;
  localparam int MODE_W   = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // largest frame count the sprite can hold
  localparam int MAX_FRAMES = 256;

  // register indexes on the write port
  localparam logic [CFG_IDX_W-1:0] REG_START_FRAME = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_FRAME   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANIM_MODE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_DELAY  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 3'd4;

  // animation modes, two's complement, sign is direction
  localparam logic [MODE_W-1:0] MODE_NONE     = 3'b000;
  localparam logic [MODE_W-1:0] MODE_ONCE_UP  = 3'b001;
  localparam logic [MODE_W-1:0] MODE_PING_UP  = 3'b010;
  localparam logic [MODE_W-1:0] MODE_WRAP_UP  = 3'b011;
  localparam logic [MODE_W-1:0] MODE_WRAP_DN  = 3'b101;
  localparam logic [MODE_W-1:0] MODE_PING_DN  = 3'b110;
  localparam logic [MODE_W-1:0] MODE_ONCE_DN  = 3'b111;

  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_START = 1'b1;

  typedef struct packed {
    logic [FRAME_W-1:0]  start_frame;
    logic [FRAME_W-1:0]  end_frame;
    logic [MODE_W-1:0]   anim_mode;
    logic [DELAY_W-1:0]  step_delay;
    logic [FCOUNT_W-1:0] frame_count;
  } cfg_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               animating;
    logic               finished;
  } res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/sfa_step.sv
// next-state logic for one tick or start request
`default_nettype none

module sfa_step #(
  parameter int DELAY_BITS = 16
) (
  input  sfa_pkg::cfg_t           cfg,
  input  logic                    req_type,
  input  logic                    visible,
  input  logic [7:0]              frame_index,
  input  logic [DELAY_BITS-1:0]   tick_count,
  input  logic                    heading_forward,
  input  logic                    running,
  output logic [7:0]              frame_index_next,
  output logic [DELAY_BITS-1:0]   tick_count_next,
  output logic                    heading_forward_next,
  output logic                    running_next,
  output sfa_pkg::res_t           res
);
  import sfa_pkg::*;

  localparam int CMP_W = (DELAY_BITS > DELAY_W) ? DELAY_BITS : DELAY_W;

  logic signed [9:0] f_cur;
  logic signed [9:0] f_up;
  logic signed [9:0] f_dn;
  logic signed [9:0] lo;
  logic signed [9:0] hi;
  logic signed [9:0] cand;
  logic              do_set;
  logic              cand_ok;
  logic              mode_pos;
  logic              mode_neg;
  logic [DELAY_BITS-1:0] tick_inc;
  logic              step;
  logic              keep;
  logic              fin;

  assign f_cur = $signed({2'b00, frame_index});
  assign f_up  = f_cur + 10'sd1;
  assign f_dn  = f_cur - 10'sd1;
  assign lo    = $signed({2'b00, cfg.start_frame});
  assign hi    = $signed({2'b00, cfg.end_frame});

  assign mode_pos = (cfg.anim_mode != MODE_NONE) && !cfg.anim_mode[MODE_W-1];
  assign mode_neg = cfg.anim_mode[MODE_W-1];

  // frame setter: only in range of the sprite and the frame limit
  assign cand_ok = !cand[9] && (cand[8:0] < cfg.frame_count)
                   && (32'(cand[8:0]) < 32'(MAX_FRAMES));

  assign tick_inc = tick_count + DELAY_BITS'(1);
  assign step = (cfg.step_delay == '0)
                || (CMP_W'(tick_inc) >= CMP_W'(cfg.step_delay));

  always_comb begin
    cand                 = f_cur;
    do_set               = 1'b0;
    fin                  = 1'b0;
    keep                 = 1'b1;
    tick_count_next      = tick_count;
    heading_forward_next = heading_forward;
    running_next         = running;

    if (req_type == REQ_START) begin
      tick_count_next      = '0;
      heading_forward_next = mode_pos;
      if (mode_pos) begin
        cand   = lo;
        do_set = 1'b1;
      end else if (mode_neg) begin
        cand   = hi;
        do_set = 1'b1;
      end
      running_next = (cfg.anim_mode != MODE_NONE) && (cfg.end_frame >= cfg.start_frame);
    end else if (visible && running) begin
      tick_count_next = tick_inc;
      if (cfg.step_delay == '0) begin
        keep            = 1'b0;
        tick_count_next = '0;
      end
      if (step) begin
        case (cfg.anim_mode)
          MODE_ONCE_UP: begin
            if (f_up <= hi) begin
              cand   = f_up;
              do_set = 1'b1;
            end else begin
              fin = 1'b1;
            end
          end
          MODE_ONCE_DN: begin
            if (f_dn >= lo) begin
              cand   = f_dn;
              do_set = 1'b1;
            end else begin
              fin = 1'b1;
            end
          end
          MODE_PING_UP, MODE_PING_DN: begin
            if (heading_forward) begin
              if (f_up <= hi) begin
                cand   = f_up;
                do_set = 1'b1;
              end else begin
                // turn at the top, step back if above frame zero
                heading_forward_next = 1'b0;
                cand   = f_dn;
                do_set = (frame_index != '0);
              end
            end else begin
              if (f_dn >= lo) begin
                cand   = f_dn;
                do_set = 1'b1;
              end else begin
                heading_forward_next = 1'b1;
                cand   = f_up;
                do_set = 1'b1;
              end
            end
          end
          MODE_WRAP_UP: begin
            cand   = (f_up <= hi) ? f_up : lo;
            do_set = 1'b1;
          end
          MODE_WRAP_DN: begin
            cand   = (f_dn >= lo) ? f_dn : hi;
            do_set = 1'b1;
          end
          default: begin
            // no mode or an unused mode code: back to frame zero and stop
            keep   = 1'b0;
            cand   = '0;
            do_set = 1'b1;
          end
        endcase
        if (fin) keep = 1'b0;
        tick_count_next = '0;
      end
      if (!keep) running_next = 1'b0;
    end
  end

  assign frame_index_next = (do_set && cand_ok) ? cand[7:0] : frame_index;

  assign res = {frame_index_next, running_next, fin};

endmodule

`default_nettype wire

FILE: hw/rtl/sprite_frame_animator.sv
// sprite frame animator: request register, step logic, result register
// an accepted request is held in the request register, its result in the result register that drives the outputs
// throughput: one request per cycle while res_ready does not stall it, set by the single step stage
// a result waiting on res_ready stalls the step stage, the request register
// keeps taking requests until both are full
// reset: frame 0, counter 0, not animating, valid flags cleared, frame_count 1
`default_nettype none

module sprite_frame_animator #(
  parameter int DELAY_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [sfa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sfa_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              req_valid,
  output logic                              req_ready,
  input  logic                              req_type,
  input  logic                              visible,
  output logic                              res_valid,
  input  logic                              res_ready,
  output logic [sfa_pkg::FRAME_W-1:0]       frame,
  output logic                              animating,
  output logic                              finished
);
  import sfa_pkg::*;

  cfg_t cfg;

  logic                  s1_valid;
  logic                  s1_type;
  logic                  s1_visible;
  logic                  s2_adv;

  logic [FRAME_W-1:0]    frame_index;
  logic [DELAY_BITS-1:0] tick_count;
  logic                  heading_forward;
  logic                  running;

  logic [FRAME_W-1:0]    frame_index_next;
  logic [DELAY_BITS-1:0] tick_count_next;
  logic                  heading_forward_next;
  logic                  running_next;
  res_t                  res_next;
  res_t                  res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_frame <= '0;
      cfg.end_frame   <= '0;
      cfg.anim_mode   <= MODE_NONE;
      cfg.step_delay  <= '0;
      cfg.frame_count <= FCOUNT_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_FRAME: cfg.start_frame <= cfg_data[FRAME_W-1:0];
        REG_END_FRAME:   cfg.end_frame   <= cfg_data[FRAME_W-1:0];
        REG_ANIM_MODE:   cfg.anim_mode   <= cfg_data[MODE_W-1:0];
        REG_STEP_DELAY:  cfg.step_delay  <= cfg_data[DELAY_W-1:0];
        REG_FRAME_COUNT: cfg.frame_count <= cfg_data[FCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign s2_adv    = !res_valid || res_ready;
  assign req_ready = !s1_valid || s2_adv;

  // request register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_ready) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      s1_type    <= req_type;
      s1_visible <= visible;
    end
  end

  sfa_step #(
    .DELAY_BITS (DELAY_BITS)
  ) u_step (
    .cfg                  (cfg),
    .req_type             (s1_type),
    .visible              (s1_visible),
    .frame_index          (frame_index),
    .tick_count           (tick_count),
    .heading_forward      (heading_forward),
    .running              (running),
    .frame_index_next     (frame_index_next),
    .tick_count_next      (tick_count_next),
    .heading_forward_next (heading_forward_next),
    .running_next         (running_next),
    .res                  (res_next)
  );

  // animation state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_index     <= '0;
      tick_count      <= '0;
      heading_forward <= 1'b0;
      running         <= 1'b0;
      res_valid       <= 1'b0;
    end else if (s2_adv) begin
      res_valid <= s1_valid;
      if (s1_valid) begin
        frame_index     <= frame_index_next;
        tick_count      <= tick_count_next;
        heading_forward <= heading_forward_next;
        running         <= running_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s1_valid) begin
      res <= res_next;
    end
  end

  assign frame     = res.frame;
  assign animating = res.animating;
  assign finished  = res.finished;

endmodule

`default_nettype wire
